// ===== hw/rtl/est_pkg.sv =====
// shared constants, types and the arctangent table for the stereo triangulation block
// used by the top level, the cordic and the checker; depends on nothing
package est_pkg;

	localparam int COORD_BITS_DEF   = 12;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int OUT_BITS_DEF     = 24;

	// angle and cordic datapath width, trig result width, angle quotient bits
	localparam int AW     = 20;
	localparam int TW     = 18;
	localparam int ANG_QW = 18;

	localparam logic [29:0]          PI_Q28          = 30'd843314857;
	localparam logic signed [AW-1:0] PI_Q16          = 20'sd205887;
	localparam logic signed [AW-1:0] HALF_PI_Q16     = 20'sd102944;
	localparam logic signed [AW-1:0] CORDIC_GAIN_Q16 = 20'sd39797;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_SAT  = 2'd1,
		ST_ZERO = 2'd2
	} status_t;

	typedef enum logic {
		REG_BASELINE = 1'b0,
		REG_WIDTH    = 1'b1
	} cfg_reg_t;

	function automatic logic signed [AW-1:0] atan_q16(input int i);
		case (i)
			0:  return 20'sd51472;
			1:  return 20'sd30386;
			2:  return 20'sd16055;
			3:  return 20'sd8150;
			4:  return 20'sd4091;
			5:  return 20'sd2047;
			6:  return 20'sd1024;
			7:  return 20'sd512;
			8:  return 20'sd256;
			9:  return 20'sd128;
			10: return 20'sd64;
			11: return 20'sd32;
			12: return 20'sd16;
			13: return 20'sd8;
			14: return 20'sd4;
			15: return 20'sd2;
			16: return 20'sd1;
			default: return '0;
		endcase
	endfunction

endpackage

// ===== hw/rtl/est_div.sv =====
// pipelined restoring unsigned divider, one quotient bit per stage, with side-band data
// quotient bits beyond QW are reported as overflow; no package dependency
module est_div #(
	parameter int NW = 46,
	parameter int DW = 26,
	parameter int QW = 18,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side_i,
	output logic [QW-1:0] quo,
	output logic          ovf,
	output logic [SW-1:0] side_o
);

	localparam int CW = ((NW > DW + QW) ? NW : DW + QW) + 1;

	logic [CW-1:0] rem_s  [QW];
	logic [DW-1:0] den_s  [QW];
	logic [QW-1:0] quo_s  [QW+1];
	logic [SW-1:0] side_s [QW+1];
	logic          ovf_s  [QW+1];

	assign rem_s[0]  = CW'(num);
	assign den_s[0]  = den;
	assign quo_s[0]  = '0;
	assign side_s[0] = side_i;
	assign ovf_s[0]  = CW'(num) >= (CW'(den) << QW);

	for (genvar j = 0; j < QW; j++) begin : g_stage
		localparam int K = QW - 1 - j;
		logic [CW-1:0] sub;
		logic          ge;

		assign sub = CW'(den_s[j]) << K;
		assign ge  = rem_s[j] >= sub;

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[j+1]  <= quo_s[j] | (QW'(ge) << K);
				side_s[j+1] <= side_s[j];
				ovf_s[j+1]  <= ovf_s[j];
			end
		end

		if (j < QW - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[j+1] <= ge ? rem_s[j] - sub : rem_s[j];
					den_s[j+1] <= den_s[j];
				end
			end
		end
	end

	assign quo    = quo_s[QW];
	assign ovf    = ovf_s[QW];
	assign side_o = side_s[QW];

endmodule

// ===== hw/rtl/est_cordic.sv =====
// pipelined rotation-mode cordic: quadrant fold stage, then one micro-rotation per stage
// depends on est_pkg for widths, gain and the arctangent table
module est_cordic import est_pkg::*; #(
	parameter int STEPS = CORDIC_STEPS_DEF
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [AW-1:0] ang,
	output logic signed [TW-1:0] sin_o,
	output logic signed [TW-1:0] cos_o
);

	logic signed [AW-1:0] x_s  [STEPS+1];
	logic signed [AW-1:0] y_s  [STEPS+1];
	logic signed [AW-1:0] z_s  [STEPS+1];
	logic                 nc_s [STEPS+1];

	logic signed [AW-1:0] fold_z;
	logic                 fold_nc;
	logic signed [AW-1:0] cos_full;

	// fold into the right half plane through sin(pi-a) and -cos(pi-a)
	always_comb begin
		if (ang > HALF_PI_Q16) begin
			fold_z  = PI_Q16 - ang;
			fold_nc = 1'b1;
		end else if (ang < -HALF_PI_Q16) begin
			fold_z  = -PI_Q16 - ang;
			fold_nc = 1'b1;
		end else begin
			fold_z  = ang;
			fold_nc = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]  <= CORDIC_GAIN_Q16;
			y_s[0]  <= '0;
			z_s[0]  <= fold_z;
			nc_s[0] <= fold_nc;
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic signed [AW-1:0] dx;
		logic signed [AW-1:0] dy;

		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;

		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][AW-1]) begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - atan_q16(i);
				end else begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + atan_q16(i);
				end
				nc_s[i+1] <= nc_s[i];
			end
		end
	end

	assign cos_full = nc_s[STEPS] ? -x_s[STEPS] : x_s[STEPS];
	assign sin_o    = y_s[STEPS][TW-1:0];
	assign cos_o    = cos_full[TW-1:0];

endmodule

// ===== hw/rtl/equirect_stereo_triangulation.sv =====
// top level of the equirectangular stereo triangulation pipeline
// depends on est_pkg, est_div and est_cordic
//
//  channel | direction | handshake                     | payload
//  cfg     | in        | cfg_valid / cfg_ready         | cfg_index, cfg_data
//  s       | in        | s_tvalid / s_tready           | s_tdata: pixel pair request
//  m       | out       | m_tvalid / m_tready           | m_tdata: point and status
//
// one request per cycle while no result waits on m_tready; the pipeline depth is set by
// the modulo stages, the two restoring dividers and the cordic
// the whole pipeline advances together; s_tready is low only while a result waits
// in the output register and m_tready is low, so a stall freezes every stage
// reset clears the valid bits and loads the register defaults; no clearing pass
module equirect_stereo_triangulation import est_pkg::*; #(
	parameter int COORD_BITS   = COORD_BITS_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
	parameter int OUT_BITS     = OUT_BITS_DEF,
	localparam int IN_W        = ((3 * COORD_BITS + 7) / 8) * 8,
	localparam int OUT_W       = ((3 * OUT_BITS + 2 + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_index,
	input  logic [15:0]      cfg_data,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // left_column, left_row, right_column
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata    // pos_x, pos_y, pos_z, status
);

	localparam int MST = COORD_BITS - 2;
	localparam int MW  = COORD_BITS + 16;
	localparam int LV  = COORD_BITS + CORDIC_STEPS + OUT_BITS + 24;
	localparam int ONW = 39;
	localparam int ODW = 18;

	logic [15:0] baseline_q;
	logic [12:0] width_q;
	logic [12:0] w_eff;
	logic [14:0] w4;
	logic [14:0] w2;
	logic [14:0] w3;
	logic        en;
	logic [LV-1:0] vld_q;
	logic        out_v_q;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			baseline_q <= 16'd100;
			width_q    <= 13'd720;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_BASELINE: baseline_q <= cfg_data;
				REG_WIDTH:    width_q    <= cfg_data[12:0];
			endcase
		end
	end

	assign w_eff = (width_q < 13'd2) ? 13'd2 : width_q;
	assign w4    = {w_eff, 2'b00};
	assign w2    = {1'b0, w_eff, 1'b0};
	assign w3    = {2'b00, w_eff} + {1'b0, w_eff, 1'b0};

	assign en       = !out_v_q || m_tready;
	assign s_tready = en;
	assign m_tvalid = out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			out_v_q <= 1'b0;
		end else if (en) begin
			vld_q   <= {vld_q[LV-2:0], s_tvalid};
			out_v_q <= vld_q[LV-1];
		end
	end

	// input register
	logic [COORD_BITS-1:0] p1_s1;
	logic [COORD_BITS-1:0] r1_s1;
	logic [COORD_BITS-1:0] p2_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s1 <= s_tdata[COORD_BITS-1:0];
			r1_s1 <= s_tdata[2*COORD_BITS-1:COORD_BITS];
			p2_s1 <= s_tdata[3*COORD_BITS-1:2*COORD_BITS];
		end
	end

	// 2p mod 4w, one compare-subtract per stage
	logic [MW-1:0] mod_s [3][MST+1];

	assign mod_s[0][0] = MW'({p1_s1, 1'b0});
	assign mod_s[1][0] = MW'({r1_s1, 1'b0});
	assign mod_s[2][0] = MW'({p2_s1, 1'b0});

	for (genvar j = 0; j < MST; j++) begin : g_mod
		localparam int K = MST - 1 - j;
		logic [MW-1:0] sub;

		assign sub = MW'(w4) << K;

		for (genvar l = 0; l < 3; l++) begin : g_lane
			always_ff @(posedge clk) begin
				if (en) begin
					mod_s[l][j+1] <= (mod_s[l][j] >= sub) ? mod_s[l][j] - sub : mod_s[l][j];
				end
			end
		end
	end

	// centre a residue in [0,4w) onto [-2w,2w): returns sign and magnitude
	function automatic logic [15:0] centre(input logic [15:0] t, input logic [14:0] h,
		input logic [14:0] f);
		if (t >= {1'b0, h}) begin
			return {1'b1, f - t[14:0]};
		end
		return {1'b0, t[14:0]};
	endfunction

	logic [15:0] ta1;
	logic [15:0] tab;
	logic [15:0] ta2;
	logic [15:0] td;
	logic [15:0] sa1;
	logic [15:0] sab;
	logic [15:0] sa2;
	logic [14:0] a1;
	logic [14:0] ab;
	logic [14:0] a2;

	assign a1 = mod_s[0][MST][14:0];
	assign ab = mod_s[1][MST][14:0];
	assign a2 = mod_s[2][MST][14:0];

	// the image-centre offset -w is +3w modulo 4w
	assign ta1 = 16'(a1) + 16'(w3);
	assign tab = 16'(ab) + 16'(w3);
	assign ta2 = 16'(a2) + 16'(w3);
	assign sa1 = (ta1 >= 16'(w4)) ? ta1 - 16'(w4) : ta1;
	assign sab = (tab >= 16'(w4)) ? tab - 16'(w4) : tab;
	assign sa2 = (ta2 >= 16'(w4)) ? ta2 - 16'(w4) : ta2;
	assign td  = (a1 >= a2) ? 16'(a1) - 16'(a2) : 16'(a1) + 16'(w4) - 16'(a2);

	logic [15:0] cen_s2 [4];

	always_ff @(posedge clk) begin
		if (en) begin
			cen_s2[0] <= centre(sa1, w2, w4);
			cen_s2[1] <= centre(sab, w2, w4);
			cen_s2[2] <= centre(sa2, w2, w4);
			cen_s2[3] <= centre(td, w2, w4);
		end
	end

	// numerator of the angle divide, rounding offset folded in
	logic [45:0] mul_s3 [4];
	logic        neg_s3 [4];

	for (genvar l = 0; l < 4; l++) begin : g_mul
		always_ff @(posedge clk) begin
			if (en) begin
				mul_s3[l] <= 46'(cen_s2[l][14:0]) * 46'(PI_Q28) + 46'({w_eff, 12'b0});
				neg_s3[l] <= cen_s2[l][15];
			end
		end
	end

	// angles in Q3.16 and their sines and cosines
	logic [ANG_QW-1:0]    angq   [4];
	logic                 angneg [4];
	logic signed [AW-1:0] ang    [4];
	logic signed [TW-1:0] sn     [4];
	logic signed [TW-1:0] cs     [3];

	for (genvar l = 0; l < 4; l++) begin : g_ang
		est_div #(
			.NW (46),
			.DW (26),
			.QW (ANG_QW),
			.SW (1)
		) u_div (
			.clk    (clk),
			.en     (en),
			.num    (mul_s3[l]),
			.den    ({w_eff, 13'b0}),
			.side_i (neg_s3[l]),
			.quo    (angq[l]),
			.ovf    (),
			.side_o (angneg[l])
		);

		assign ang[l] = angneg[l] ? -AW'(angq[l]) : AW'(angq[l]);
	end

	for (genvar l = 0; l < 3; l++) begin : g_trig
		est_cordic #(
			.STEPS (CORDIC_STEPS)
		) u_cordic (
			.clk   (clk),
			.en    (en),
			.ang   (ang[l]),
			.sin_o (sn[l]),
			.cos_o (cs[l])
		);
	end

	// only the sine of the disparity matters
	est_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic_d (
		.clk   (clk),
		.en    (en),
		.ang   (ang[3]),
		.sin_o (sn[3]),
		.cos_o ()
	);

	// products
	logic signed [34:0]   num_s4;
	logic signed [35:0]   tp_s4;
	logic signed [35:0]   up_s4;
	logic signed [TW-1:0] s1_s4;
	logic signed [TW-1:0] sd_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s4 <= $signed({1'b0, baseline_q}) * cs[2];
			tp_s4  <= cs[0] * sn[1];
			up_s4  <= cs[0] * cs[1];
			s1_s4  <= sn[0];
			sd_s4  <= sn[3];
		end
	end

	// divide by 2^16 with rounding half away from zero
	function automatic logic signed [TW-1:0] rnd16(input logic signed [35:0] v);
		logic signed [36:0] ve;
		logic [36:0]        mag;
		logic [36:0]        r;
		ve  = 37'(v);
		mag = v[35] ? $unsigned(-ve) : $unsigned(ve);
		r   = (mag + 37'd32768) >> 16;
		return v[35] ? TW'(-r) : TW'(r);
	endfunction

	logic signed [34:0]   num_s5;
	logic signed [TW-1:0] t_s5;
	logic signed [TW-1:0] u_s5;
	logic signed [TW-1:0] s1_s5;
	logic signed [TW-1:0] sd_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s5 <= num_s4;
			t_s5   <= rnd16(tp_s4);
			u_s5   <= rnd16(up_s4);
			s1_s5  <= s1_s4;
			sd_s5  <= sd_s4;
		end
	end

	logic signed [52:0]   n_s6 [3];
	logic signed [TW-1:0] sd_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			n_s6[0] <= num_s5 * s1_s5;
			n_s6[1] <= num_s5 * t_s5;
			n_s6[2] <= num_s5 * u_s5;
			sd_s6   <= sd_s5;
		end
	end

	// round(n / (sd * 2^16)) = floor(((|n| + |sd|*2^15) >> 16) / |sd|)
	logic signed [TW:0]  sde;
	logic [ODW-1:0]      sdm;
	logic [ONW-1:0]      m_s7 [3];
	logic                sg_s7 [3];
	logic [ODW-1:0]      sdm_s7;
	logic                zero_s7;

	assign sde = (TW+1)'(sd_s6);
	assign sdm = sd_s6[TW-1] ? ODW'($unsigned(-sde)) : ODW'($unsigned(sde));

	for (genvar l = 0; l < 3; l++) begin : g_pre
		logic signed [53:0] ne;
		logic [54:0]        mag;

		assign ne  = 54'(n_s6[l]);
		assign mag = 55'(n_s6[l][52] ? $unsigned(-ne) : $unsigned(ne)) + (55'(sdm) << 15);

		always_ff @(posedge clk) begin
			if (en) begin
				m_s7[l]  <= mag[54:16];
				sg_s7[l] <= n_s6[l][52] ^ sd_s6[TW-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sdm_s7  <= sdm;
			zero_s7 <= (sd_s6 == '0);
		end
	end

	logic [OUT_BITS-1:0] q    [3];
	logic                qovf [3];
	logic                qneg [3];
	logic                qzero;

	est_div #(
		.NW (ONW),
		.DW (ODW),
		.QW (OUT_BITS),
		.SW (2)
	) u_div_x (
		.clk    (clk),
		.en     (en),
		.num    (m_s7[0]),
		.den    (sdm_s7),
		.side_i ({zero_s7, sg_s7[0]}),
		.quo    (q[0]),
		.ovf    (qovf[0]),
		.side_o ({qzero, qneg[0]})
	);

	for (genvar l = 1; l < 3; l++) begin : g_out_div
		est_div #(
			.NW (ONW),
			.DW (ODW),
			.QW (OUT_BITS),
			.SW (1)
		) u_div (
			.clk    (clk),
			.en     (en),
			.num    (m_s7[l]),
			.den    (sdm_s7),
			.side_i (sg_s7[l]),
			.quo    (q[l]),
			.ovf    (qovf[l]),
			.side_o (qneg[l])
		);
	end

	// clamp to the signed output range; returns saturation flag and value
	function automatic logic [OUT_BITS:0] clamp(input logic [OUT_BITS-1:0] qv,
		input logic ov, input logic ng);
		logic big;
		big = ov || (qv[OUT_BITS-1] && (!ng || (qv[OUT_BITS-2:0] != '0)));
		if (big) begin
			return ng ? {2'b11, {(OUT_BITS-1){1'b0}}} : {2'b10, {(OUT_BITS-1){1'b1}}};
		end
		return {1'b0, ng ? -qv : qv};
	endfunction

	logic [OUT_BITS:0]   cl [3];
	logic [OUT_BITS-1:0] pos_q [3];
	status_t             status_q;

	for (genvar l = 0; l < 3; l++) begin : g_clamp
		assign cl[l] = clamp(q[l], qovf[l], qneg[l]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (qzero) begin
				pos_q[0] <= '0;
				pos_q[1] <= '0;
				pos_q[2] <= '0;
				status_q <= ST_ZERO;
			end else begin
				pos_q[0] <= cl[0][OUT_BITS-1:0];
				pos_q[1] <= cl[1][OUT_BITS-1:0];
				pos_q[2] <= cl[2][OUT_BITS-1:0];
				status_q <= (cl[0][OUT_BITS] || cl[1][OUT_BITS] || cl[2][OUT_BITS]) ?
					ST_SAT : ST_OK;
			end
		end
	end

	assign m_tdata = OUT_W'({status_q, pos_q[2], pos_q[1], pos_q[0]});

endmodule

// ===== hw/rtl/est_checker.sv =====
// port-level checker for the stereo triangulation block, bound to the top level
// depends on est_pkg for the status codes
module est_checker import est_pkg::*; #(
	parameter int OUT_BITS = OUT_BITS_DEF,
	localparam int OUT_W   = ((3 * OUT_BITS + 2 + 7) / 8) * 8
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	logic [1:0] st;

	assign st = m_tdata[3*OUT_BITS +: 2];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	// the pipeline only freezes for a waiting result
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output stall");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && st == ST_ZERO |-> m_tdata[3*OUT_BITS-1:0] == '0)
		else $error("zero disparity result carries a point");

endmodule

bind equirect_stereo_triangulation est_checker #(
	.OUT_BITS (OUT_BITS)
) u_est_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
